// File: src/gntk_pkg.sv
// Shared types, constants and the gate function for the gate netlist tick engine.
// Used by gntk_core and gate_netlist_tick_engine; depends on nothing else.
package gntk_pkg;

	localparam int GATE_DEPTH = 256;
	localparam int WIRE_DEPTH = 256;
	localparam int GATE_AW    = $clog2(GATE_DEPTH);
	localparam int WIRE_AW    = $clog2(WIRE_DEPTH);
	localparam int CNT_W      = 9;
	localparam int IDX_W      = GATE_AW + 1;
	localparam int CLR_DEPTH  = (GATE_DEPTH > WIRE_DEPTH) ? GATE_DEPTH : WIRE_DEPTH;
	localparam int CLR_AW     = $clog2(CLR_DEPTH);

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		GT_NOT = 2'd0,
		GT_OR  = 2'd1,
		GT_AND = 2'd2,
		GT_XOR = 2'd3
	} gate_type_t;

	typedef enum logic {
		REG_GATE_COUNT = 1'b0,
		REG_WIRE_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_RDATA,
		ST_SAVE,
		ST_DRIVE,
		ST_EV_TAB,
		ST_EV_A,
		ST_EV_B,
		ST_EV_C,
		ST_EV_WR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [WIRE_AW-1:0] out_w;
		logic [WIRE_AW-1:0] in_c;
		logic [WIRE_AW-1:0] in_b;
		logic [WIRE_AW-1:0] in_a;
		logic               connected;
		logic               three;
		gate_type_t         gtype;
	} gate_entry_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [GATE_AW-1:0] gate_index;
		gate_entry_t        entry;
		logic [WIRE_AW-1:0] wire_index;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       level;
		logic       previous_level;
	} res_t;

	function automatic logic gate_eval(gate_type_t t, logic three, logic a, logic b, logic c);
		logic cc;
		logic r;
		cc = three & c;
		case (t)
			GT_NOT:  r = ~a;
			GT_OR:   r = a | b | cc;
			GT_AND:  r = three ? (a & b & c) : (a & b);
			GT_XOR:  r = a ^ b ^ cc;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: src/gntk_core.sv
// Sequencer and state memories of the gate netlist tick engine.
// Depends on gntk_pkg; instantiated by gate_netlist_tick_engine.
module gntk_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  gntk_pkg::cmd_t           cmd,
	input  logic [gntk_pkg::CNT_W-1:0] gate_count,
	input  logic [gntk_pkg::CNT_W-1:0] wire_count,
	output logic                     res_valid,
	input  logic                     res_ready,
	output gntk_pkg::res_t           res
);
	import gntk_pkg::*;

	gate_entry_t gtab_mem [GATE_DEPTH];
	logic        gout_mem [GATE_DEPTH];
	logic        wlev_mem [WIRE_DEPTH];
	logic        wprev_mem [WIRE_DEPTH];

	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CLR_AW-1:0] clr_q, clr_d;
	logic [CNT_W-1:0] gc_sat, wc_sat;

	logic              gtab_we, gtab_re;
	logic [GATE_AW-1:0] gtab_waddr, gtab_raddr;
	gate_entry_t       gtab_wdata, gtab_rdata;

	logic              gout_we, gout_re, gout_wdata, gout_rdata;
	logic [GATE_AW-1:0] gout_waddr, gout_raddr;

	logic              wlev_we, wlev_re, wlev_wdata, wlev_rdata;
	logic [WIRE_AW-1:0] wlev_waddr, wlev_raddr;

	logic              wprev_we, wprev_re, wprev_wdata, wprev_rdata;
	logic [WIRE_AW-1:0] wprev_waddr, wprev_raddr;

	logic              save_pend_d, save_pend_s1;
	logic [WIRE_AW-1:0] save_addr_s1;
	logic              drive_pend_d, drive_pend_s1;
	logic              a_q, b_q;
	logic [1:0]        op_q;
	logic              level_q, prev_q;
	logic              accept;

	assign gc_sat = gate_count > CNT_W'(GATE_DEPTH) ? CNT_W'(GATE_DEPTH) : gate_count;
	assign wc_sat = wire_count > CNT_W'(WIRE_DEPTH) ? CNT_W'(WIRE_DEPTH) : wire_count;
	assign accept = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (gtab_we)
			gtab_mem[gtab_waddr] <= gtab_wdata;
		if (gtab_re)
			gtab_rdata <= gtab_mem[gtab_raddr];
	end

	always_ff @(posedge clk) begin
		if (gout_we)
			gout_mem[gout_waddr] <= gout_wdata;
		if (gout_re)
			gout_rdata <= gout_mem[gout_raddr];
	end

	always_ff @(posedge clk) begin
		if (wlev_we)
			wlev_mem[wlev_waddr] <= wlev_wdata;
		if (wlev_re)
			wlev_rdata <= wlev_mem[wlev_raddr];
	end

	always_ff @(posedge clk) begin
		if (wprev_we)
			wprev_mem[wprev_waddr] <= wprev_wdata;
		if (wprev_re)
			wprev_rdata <= wprev_mem[wprev_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			idx_q         <= '0;
			clr_q         <= '0;
			save_pend_s1  <= 1'b0;
			drive_pend_s1 <= 1'b0;
		end else begin
			state_q       <= state_d;
			idx_q         <= idx_d;
			clr_q         <= clr_d;
			save_pend_s1  <= save_pend_d;
			drive_pend_s1 <= drive_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		save_addr_s1 <= idx_q[WIRE_AW-1:0];
		if (state_q == ST_EV_B)
			a_q <= wlev_rdata;
		if (state_q == ST_EV_C)
			b_q <= wlev_rdata;
		if (accept) begin
			op_q    <= cmd.op;
			level_q <= 1'b0;
			prev_q  <= 1'b0;
		end else if (state_q == ST_RDATA) begin
			level_q <= wlev_rdata;
			prev_q  <= wprev_rdata;
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		clr_d        = clr_q;
		cmd_ready    = 1'b0;
		res_valid    = 1'b0;
		save_pend_d  = 1'b0;
		drive_pend_d = 1'b0;

		gtab_we    = 1'b0;
		gtab_waddr = cmd.gate_index;
		gtab_wdata = cmd.entry;
		gtab_re    = 1'b0;
		gtab_raddr = idx_q[GATE_AW-1:0];

		gout_we    = 1'b0;
		gout_waddr = idx_q[GATE_AW-1:0];
		gout_wdata = 1'b0;
		gout_re    = 1'b0;
		gout_raddr = idx_q[GATE_AW-1:0];

		wlev_we    = 1'b0;
		wlev_waddr = idx_q[WIRE_AW-1:0];
		wlev_wdata = 1'b0;
		wlev_re    = 1'b0;
		wlev_raddr = idx_q[WIRE_AW-1:0];

		wprev_we    = 1'b0;
		wprev_waddr = save_addr_s1;
		wprev_wdata = wlev_rdata;
		wprev_re    = 1'b0;
		wprev_raddr = cmd.wire_index;

		// Second halves of the pipelined save and drive passes.
		if (save_pend_s1)
			wprev_we = 1'b1;
		if (drive_pend_s1 && gtab_rdata.connected && gout_rdata) begin
			wlev_we    = 1'b1;
			wlev_waddr = gtab_rdata.out_w;
			wlev_wdata = 1'b1;
		end

		case (state_q)
			ST_CLR: begin
				gout_we     = 1'b1;
				gout_waddr  = clr_q[GATE_AW-1:0];
				wlev_we     = 1'b1;
				wlev_waddr  = clr_q[WIRE_AW-1:0];
				wprev_we    = 1'b1;
				wprev_waddr = clr_q[WIRE_AW-1:0];
				wprev_wdata = 1'b0;
				clr_d       = clr_q + 1'b1;
				if (clr_q == CLR_AW'(CLR_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					case (cmd.op)
						OP_LOAD: begin
							gtab_we = 1'b1;
							state_d = ST_DONE;
						end
						OP_TICK: begin
							idx_d   = '0;
							state_d = ST_SAVE;
						end
						OP_READ: begin
							wlev_re    = 1'b1;
							wlev_raddr = cmd.wire_index;
							wprev_re   = 1'b1;
							state_d    = ST_RDATA;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_RDATA: state_d = ST_DONE;
			ST_SAVE: begin
				if (CNT_W'(idx_q) < wc_sat) begin
					wlev_re     = 1'b1;
					wlev_we     = 1'b1;
					save_pend_d = 1'b1;
					idx_d       = idx_q + 1'b1;
				end else begin
					idx_d   = '0;
					state_d = ST_DRIVE;
				end
			end
			ST_DRIVE: begin
				if (CNT_W'(idx_q) < gc_sat) begin
					gtab_re      = 1'b1;
					gout_re      = 1'b1;
					drive_pend_d = 1'b1;
					idx_d        = idx_q + 1'b1;
				end else begin
					idx_d   = '0;
					state_d = ST_EV_TAB;
				end
			end
			ST_EV_TAB: begin
				if (CNT_W'(idx_q) < gc_sat) begin
					gtab_re = 1'b1;
					state_d = ST_EV_A;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EV_A: begin
				if (!gtab_rdata.connected) begin
					idx_d   = idx_q + 1'b1;
					state_d = ST_EV_TAB;
				end else begin
					wlev_re    = 1'b1;
					wlev_raddr = gtab_rdata.in_a;
					state_d    = ST_EV_B;
				end
			end
			ST_EV_B: begin
				wlev_re    = 1'b1;
				wlev_raddr = gtab_rdata.in_b;
				state_d    = ST_EV_C;
			end
			ST_EV_C: begin
				wlev_re    = 1'b1;
				wlev_raddr = gtab_rdata.in_c;
				state_d    = ST_EV_WR;
			end
			ST_EV_WR: begin
				gout_we    = 1'b1;
				gout_wdata = gate_eval(gtab_rdata.gtype, gtab_rdata.three,
					a_q, b_q, wlev_rdata);
				idx_d      = idx_q + 1'b1;
				state_d    = ST_EV_TAB;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res.op             = op_q;
	assign res.level          = level_q;
	assign res.previous_level = prev_q;

	// The wire store must stay untouched while a gate reads its inputs.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV_B || state_q == ST_EV_C || state_q == ST_EV_WR) |-> !wlev_we)
		else $error("wire store written during gate evaluation");

	assert property (@(posedge clk) disable iff (!arst_n)
		save_pend_s1 |-> $past(state_q == ST_SAVE))
		else $error("save write without a save read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV_WR) |-> gtab_rdata.connected)
		else $error("unconnected gate evaluated");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRIVE || state_q == ST_EV_TAB) |-> CNT_W'(idx_q) <= gc_sat)
		else $error("gate index ran past the gate count");

	assert property (@(posedge clk) disable iff (!arst_n)
		drive_pend_s1 |-> !save_pend_s1)
		else $error("save and drive passes overlap");

endmodule

// File: src/gate_netlist_tick_engine.sv
// Top level of the gate netlist tick engine: stream ports, configuration
// registers and the result register. Depends on gntk_pkg and gntk_core.
//
// Each input item is a load, a tick or a read, and gives exactly one result
// item. After reset the block clears its gate-output and wire memories and
// takes no item in that time; configuration writes are taken at any time.
// The work of a tick grows with wire_count and gate_count, both clamped to
// 256, and is larger for a connected gate than for one that is not. The gate
// pass dominates: the wire memory has one read port and reads each gate's
// inputs one per cycle. The next item is taken as soon as the result moves
// to the output register, even if the sink has not taken it yet.
module gate_netlist_tick_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// gate_index[7:0], gate_type[9:8], three_inputs[10], connected[11],
	// in_a[19:12], in_b[27:20], in_c[35:28], out_wire[43:36], wire_index[51:44]
	input  logic [55:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// level[0], previous_level[1]
	output logic [7:0]  m_tdata,
	// completed_op[1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata
);
	import gntk_pkg::*;

	cmd_t cmd;
	res_t res;
	logic res_valid, out_free;
	logic [CNT_W-1:0] gate_count_q, wire_count_q;
	logic m_tvalid_q;
	res_t out_q;

	assign cmd.op               = s_tuser;
	assign cmd.gate_index       = s_tdata[7:0];
	assign cmd.entry.gtype      = gate_type_t'(s_tdata[9:8]);
	assign cmd.entry.three      = s_tdata[10];
	assign cmd.entry.connected  = s_tdata[11];
	assign cmd.entry.in_a       = s_tdata[19:12];
	assign cmd.entry.in_b       = s_tdata[27:20];
	assign cmd.entry.in_c       = s_tdata[35:28];
	assign cmd.entry.out_w      = s_tdata[43:36];
	assign cmd.wire_index       = s_tdata[51:44];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_count_q <= '0;
			wire_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GATE_COUNT: gate_count_q <= cfg_wdata;
				REG_WIRE_COUNT: wire_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	gntk_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (s_tvalid),
		.cmd_ready  (s_tready),
		.cmd        (cmd),
		.gate_count (gate_count_q),
		.wire_count (wire_count_q),
		.res_valid  (res_valid),
		.res_ready  (out_free),
		.res        (res)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_valid && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free)
			out_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_q.op;
	assign m_tdata  = {6'b0, out_q.previous_level, out_q.level};

endmodule

// File: dv/gntk_checker.sv
// Checker for the gate netlist tick engine: watches the configuration port and both
// streams, keeps its own netlist and wire state, and compares every result item.
// Depends on gntk_pkg for the gate entry layout, op and register codes.
module gntk_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [8:0]  cfg_wdata,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import gntk_pkg::*;

	gate_entry_t netlist    [GATE_DEPTH];
	logic        gate_state [GATE_DEPTH];
	logic        wire_level [WIRE_DEPTH];
	logic        wire_prev  [WIRE_DEPTH];
	logic [8:0]  gate_limit;
	logic [8:0]  wire_limit;
	res_t        expected_results [$];
	res_t        want;
	int          result_no;

	task automatic report(input string what, input int exp_val, input int got_val);
		$display("%0t ns: result %0d: %s: expected %0d, got %0d",
			$time, result_no, what, exp_val, got_val);
		fails++;
	endtask

	function automatic logic gate_value(gate_entry_t g);
		int ones;
		int need;
		ones = int'(wire_level[g.in_a]) + int'(wire_level[g.in_b]);
		if (g.three) begin
			ones += int'(wire_level[g.in_c]);
		end
		need = g.three ? 3 : 2;
		case (g.gtype)
			GT_NOT:  return !wire_level[g.in_a];
			GT_OR:   return ones > 0;
			GT_AND:  return ones == need;
			default: return ones[0];
		endcase
	endfunction

	function automatic res_t netlist_answer(logic [1:0] op, logic [55:0] data);
		res_t r;
		int gc;
		int wc;
		r = '0;
		r.op = op;
		case (op)
			OP_LOAD: begin
				netlist[data[7:0]] = gate_entry_t'(data[43:8]);
			end
			OP_TICK: begin
				gc = (gate_limit > GATE_DEPTH) ? GATE_DEPTH : int'(gate_limit);
				wc = (wire_limit > WIRE_DEPTH) ? WIRE_DEPTH : int'(wire_limit);
				for (int i = 0; i < wc; i++) begin
					wire_prev[i] = wire_level[i];
					wire_level[i] = 1'b0;
				end
				for (int i = 0; i < gc; i++) begin
					if (netlist[i].connected && gate_state[i]) begin
						wire_level[netlist[i].out_w] = 1'b1;
					end
				end
				for (int i = 0; i < gc; i++) begin
					if (netlist[i].connected) begin
						gate_state[i] = gate_value(netlist[i]);
					end
				end
			end
			OP_READ: begin
				r.level = wire_level[data[51:44]];
				r.previous_level = wire_prev[data[51:44]];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < GATE_DEPTH; i++) begin
				netlist[i] = '0;
				gate_state[i] = 1'b0;
			end
			for (int i = 0; i < WIRE_DEPTH; i++) begin
				wire_level[i] = 1'b0;
				wire_prev[i] = 1'b0;
			end
			gate_limit = '0;
			wire_limit = '0;
			expected_results.delete();
			fails = 0;
			pending = 0;
			result_no = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report("result item with nothing expected", 0, int'(m_tuser));
				end else begin
					want = expected_results.pop_front();
					if (m_tuser !== want.op) begin
						report("completed_op", int'(want.op), int'(m_tuser));
					end
					if (m_tdata[0] !== want.level) begin
						report("level", int'(want.level), int'(m_tdata[0]));
					end
					if (m_tdata[1] !== want.previous_level) begin
						report("previous_level", int'(want.previous_level),
							int'(m_tdata[1]));
					end
				end
				result_no++;
			end
			if (cfg_we) begin
				if (cfg_addr == REG_GATE_COUNT) begin
					gate_limit = cfg_wdata;
				end else begin
					wire_limit = cfg_wdata;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(netlist_answer(s_tuser, s_tdata));
			end
			pending = expected_results.size();
		end
	end

endmodule

// File: dv/tb_top.sv
// Top of the gate netlist tick engine testbench: clock, reset, stimulus and verdict.
// Loads netlists, runs ticks and reads wires under several gate and wire counts,
// with random idling on both streams. Depends on gntk_pkg, gntk_checker and the block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gntk_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we    = 1'b0;
	logic        cfg_addr  = 1'b0;
	logic [8:0]  cfg_wdata = '0;
	int          fails;
	int          pending;
	int          results_seen = 0;
	bit          calm = 1'b0;

	gate_netlist_tick_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	gntk_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_wire(int lim);
		int hi;
		hi = lim + 1;
		if (hi > 255) begin
			hi = 255;
		end
		if (hi < 3) begin
			hi = 3;
		end
		if ($urandom_range(0, 4) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'($urandom_range(0, hi));
	endfunction

	function automatic gate_entry_t mk_gate(gate_type_t t, logic three, logic conn,
			logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] o);
		gate_entry_t e;
		e.gtype = t;
		e.three = three;
		e.connected = conn;
		e.in_a = a;
		e.in_b = b;
		e.in_c = c;
		e.out_w = o;
		return e;
	endfunction

	function automatic gate_entry_t random_gate(int lim);
		return mk_gate(gate_type_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			$urandom_range(0, 9) != 0, pick_wire(lim), pick_wire(lim), pick_wire(lim),
			pick_wire(lim));
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [55:0] data);
		int gap;
		gap = (!calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
	endtask

	task automatic load_gate(input logic [7:0] idx, input gate_entry_t e);
		send_item(OP_LOAD, {4'b0, 8'($urandom), e, idx});
	endtask

	task automatic read_wire(input logic [7:0] w);
		send_item(OP_READ, {4'b0, w, 36'({$urandom, $urandom}), 8'($urandom)});
	endtask

	task automatic tick();
		send_item(OP_TICK, {4'b0, 52'({$urandom, $urandom})});
	endtask

	task automatic set_counts(input int gates, input int wires);
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_GATE_COUNT;
		cfg_wdata <= 9'(gates);
		@(negedge clk);
		cfg_addr <= REG_WIRE_COUNT;
		cfg_wdata <= 9'(wires);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item(input int gl, input int wl);
		int r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			if (gl > 0 && $urandom_range(0, 3) != 0) begin
				load_gate(8'($urandom_range(0, gl - 1)), random_gate(wl));
			end else begin
				load_gate(8'($urandom_range(0, 255)), random_gate(wl));
			end
		end else if (r < 55) begin
			tick();
		end else if (r < 95) begin
			read_wire(pick_wire(wl));
		end else begin
			send_item(OP_UNUSED, {4'b0, 52'({$urandom, $urandom})});
		end
	endtask

	task automatic run_phase(input int gates, input int wires, input int n);
		int gl;
		int wl;
		gl = (gates > GATE_DEPTH) ? GATE_DEPTH : gates;
		wl = (wires > WIRE_DEPTH) ? WIRE_DEPTH : wires;
		set_counts(gates, wires);
		for (int i = 0; i < n; i++) begin
			random_item(gl, wl);
		end
	endtask

	initial begin : sink
		int gap_left;
		int hold_left;
		bit first_hold;
		bit second_hold;
		gap_left = 0;
		hold_left = 0;
		first_hold = 1'b0;
		second_hold = 1'b0;
		forever begin
			@(negedge clk);
			if (!first_hold && results_seen >= 300) begin
				first_hold = 1'b1;
				hold_left = 600;
			end else if (!second_hold && results_seen >= 550) begin
				second_hold = 1'b1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				m_tready <= 1'b0;
				gap_left--;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				gap_left = idle_len() - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int phase_gates [11];
		int phase_wires [11];
		phase_gates = '{256, 511, 0, 16, 8, 40, 1, 32, 3, 256, 0};
		phase_wires = '{256, 511, 5, 16, 40, 8, 1, 32, 256, 20, 0};
		phase_gates[10] = $urandom_range(0, 64);
		phase_wires[10] = $urandom_range(0, 64);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_counts(0, 0);
		send_item(OP_UNUSED, {4'b0, {52{1'b1}}});
		read_wire(8'd0);
		read_wire(8'd255);
		tick();
		load_gate(8'd0, mk_gate(GT_NOT, 1'b1, 1'b1, 8'd0, 8'd7, 8'd9, 8'd1));
		load_gate(8'd1, mk_gate(GT_OR, 1'b1, 1'b1, 8'd1, 8'd2, 8'd3, 8'd2));
		load_gate(8'd2, mk_gate(GT_AND, 1'b0, 1'b1, 8'd1, 8'd0, 8'd5, 8'd3));
		load_gate(8'd3, mk_gate(GT_XOR, 1'b1, 1'b1, 8'd1, 8'd2, 8'd255, 8'd4));
		load_gate(8'd4, mk_gate(GT_AND, 1'b1, 1'b1, 8'd1, 8'd2, 8'd3, 8'd5));
		load_gate(8'd5, mk_gate(GT_NOT, 1'b0, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
		load_gate(8'd255, mk_gate(GT_XOR, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255));

		// Wires 4 and 5 are driven but lie above the wire count, so ticks never clear them.
		set_counts(6, 4);
		for (int i = 0; i < 3; i++) begin
			tick();
			read_wire(8'(i + 1));
			read_wire(8'(i + 3));
		end

		for (int g = 0; g < GATE_DEPTH; g++) begin
			load_gate(8'(g), random_gate(8));
			if ($urandom_range(0, 3) == 0) begin
				random_item(6, 4);
			end
		end

		for (int p = 0; p < 11; p++) begin
			calm = (p % 3 == 1);
			run_phase(phase_gates[p], phase_wires[p], (phase_gates[p] >= 256) ? 30 : 45);
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (40) @(negedge clk);
		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
src/gntk_pkg.sv
src/gntk_core.sv
src/gate_netlist_tick_engine.sv
dv/gntk_checker.sv
dv/tb_top.sv
